// ===== rtl/core/b64d_pkg.sv =====
package b64d_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned SextetW = 6;
	localparam int unsigned GroupW  = 24;
	localparam int unsigned MaxRes  = 3;
	localparam int unsigned CntW    = 2;

	localparam logic [CharW-1:0] PAD_CHAR   = 8'h3D;
	localparam logic [CharW-1:0] PLUS_CHAR  = 8'h2B;
	localparam logic [CharW-1:0] SLASH_CHAR = 8'h2F;
	localparam logic [SextetW-1:0] PLUS_VAL  = 6'd62;
	localparam logic [SextetW-1:0] SLASH_VAL = 6'd63;
	localparam logic [CntW-1:0] PAD_SAT = 2'd3;

	// Character as held in the input register
	typedef struct packed {
		logic [SextetW-1:0] sextet;
		logic               keep;
		logic               pad;
		logic               eot;
	} char_t;

	typedef struct packed {
		logic [CharW-1:0] data;
		logic             byte_valid;
		logic             length_error;
		logic             last_of_run;
	} res_t;

	// Results of one character, entry 0 first
	typedef struct packed {
		logic [CntW-1:0]    cnt;
		res_t [MaxRes-1:0]  res;
	} bundle_t;

	function automatic char_t classify(input logic [CharW-1:0] c, input logic eot);
		char_t r;
		r.eot    = eot;
		r.pad    = (c == PAD_CHAR);
		r.keep   = 1'b1;
		r.sextet = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.sextet = SextetW'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.sextet = SextetW'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.sextet = SextetW'(c - 8'h30 + 8'd52);
		end else if (c == PLUS_CHAR) begin
			r.sextet = PLUS_VAL;
		end else if (c == SLASH_CHAR) begin
			r.sextet = SLASH_VAL;
		end else if (!r.pad) begin
			r.keep = 1'b0;
		end
		return r;
	endfunction

	function automatic res_t pick(input bundle_t b, input logic [CntW-1:0] idx);
		res_t r;
		case (idx)
			2'd0:    r = b.res[0];
			2'd1:    r = b.res[1];
			default: r = b.res[2];
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/b64d_quad.sv =====
module b64d_quad (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::char_t  ch,
	input  logic             take,
	output b64d_pkg::bundle_t bundle
);

	logic [b64d_pkg::GroupW-1:0] group_q;
	logic [b64d_pkg::CntW-1:0]   count_q;
	logic [b64d_pkg::CntW-1:0]   pad_q;

	logic [b64d_pkg::GroupW-1:0] grp_n;
	logic [b64d_pkg::CntW-1:0]   pad_n;
	logic [b64d_pkg::CntW-1:0]   nbytes;
	logic                        complete;
	logic                        partial;
	logic                        clean;
	logic                        closing;

	always_comb begin
		pad_n    = pad_q;
		if (ch.pad && pad_q != b64d_pkg::PAD_SAT) begin
			pad_n = pad_q + 2'd1;
		end
		grp_n    = {group_q[b64d_pkg::GroupW-b64d_pkg::SextetW-1:0],
			(ch.pad ? '0 : ch.sextet)};
		complete = ch.keep && (count_q == 2'd3);
		nbytes   = '0;
		if (complete && pad_n != b64d_pkg::PAD_SAT) begin
			nbytes = 2'd3 - pad_n;
		end
		partial  = ch.keep ? !complete : (count_q != 2'd0);
		clean    = complete && (nbytes != 2'd0);
		closing  = ch.eot && !clean;
	end

	always_comb begin
		bundle.cnt = nbytes + {1'b0, closing};
		for (int i = 0; i < b64d_pkg::MaxRes; i++) begin
			bundle.res[i] = '0;
			if (2'(i) < nbytes) begin
				bundle.res[i].data        = grp_n[b64d_pkg::GroupW-1-8*i -: 8];
				bundle.res[i].byte_valid  = 1'b1;
				bundle.res[i].last_of_run = ch.eot && (2'(i) == nbytes - 2'd1);
			end else if (closing && 2'(i) == nbytes) begin
				bundle.res[i].length_error = partial;
				bundle.res[i].last_of_run  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			count_q <= '0;
			pad_q   <= '0;
		end else if (take) begin
			if (ch.eot || complete) begin
				group_q <= '0;
				count_q <= '0;
				pad_q   <= '0;
			end else if (ch.keep) begin
				group_q <= grp_n;
				count_q <= count_q + 2'd1;
				pad_q   <= pad_n;
			end
		end
	end

endmodule

// ===== rtl/core/b64d_serial.sv =====
module b64d_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  b64d_pkg::bundle_t bundle,
	input  logic              push,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_ready,
	output b64d_pkg::res_t    out_res
);

	b64d_pkg::bundle_t         bundle_q;
	logic [b64d_pkg::CntW-1:0] idx_q;
	logic                      full_q;
	logic                      at_end;
	logic                      pop;

	assign out_valid = full_q;
	assign out_res   = b64d_pkg::pick(bundle_q, idx_q);
	assign at_end    = (idx_q == bundle_q.cnt - 2'd1);
	assign pop       = full_q && out_ready && at_end;
	assign ready     = !full_q || pop;

	always_ff @(posedge clk) begin
		if (push && ready) begin
			bundle_q <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (push && ready) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop) begin
			full_q <= 1'b0;
		end else if (full_q && out_ready) begin
			// advance to the next beat of this character
			idx_q <= idx_q + 2'd1;
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (bundle_q.cnt != 2'd0 && idx_q < bundle_q.cnt))
		else $error("serialiser index beyond bundle");
	a_closing_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !out_res.byte_valid) |-> (out_res.last_of_run && at_end))
		else $error("closing beat not last");
	a_err_only_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && out_res.length_error) |-> !out_res.byte_valid)
		else $error("length error on data beat");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !out_ready) |=> (full_q && $stable(idx_q)))
		else $error("beat moved while stalled");
`endif

endmodule

// ===== rtl/core/base64_stream_decoder_top.sv =====
// Streaming Base64 decoder, standard alphabet with '=' padding.
// Input: one character byte per beat on s_axis (tdata), s_axis_tlast marks
// the final character of a text. Characters that are neither in the alphabet
// nor '=' are dropped. Every fourth kept character closes a quad and yields 3, 2, 1
// or no data bytes on m_axis (fewer with padding). At the end of a
// text a closing beat (tuser byte_valid low, tlast high) follows unless the
// character with tlast closes a quad cleanly, when that quad's last byte carries
// tlast; length_error on the closing beat means the run must be discarded.
// The character that completes a quad is held in the input register; once the
// serialiser is ready, its bytes are loaded into the serialiser's bundle register.
// Throughput: one character per cycle while the output keeps up; a quad's
// bytes leave at one beat per cycle while m_axis is ready, from the output
// serialiser, which takes a new quad as its last beat goes.
// When m_axis stalls, characters that yield no beats keep flowing in; the
// input register holds a quad-closing or end-of-text character that yields
// beats until the serialiser frees.
// Reset clears the quad state and empties both registers.
module base64_stream_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_char
	input  logic       s_axis_tlast,  // end_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [1:0] m_axis_tuser,  // [0] byte_valid, [1] length_error
	output logic       m_axis_tlast   // last_of_run
);

	b64d_pkg::char_t   char_s1;
	logic              valid_s1;
	b64d_pkg::bundle_t bundle;
	logic              ser_ready;
	logic              take;
	logic              push;
	b64d_pkg::res_t    out_res;

	assign push          = valid_s1 && (bundle.cnt != 2'd0);
	assign take          = valid_s1 && (bundle.cnt == 2'd0 || ser_ready);
	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= b64d_pkg::classify(s_axis_tdata, s_axis_tlast);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	b64d_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (char_s1),
		.take   (take),
		.bundle (bundle)
	);

	b64d_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.push      (push),
		.ready     (ser_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.data;
	assign m_axis_tuser = {out_res.length_error, out_res.byte_valid};
	assign m_axis_tlast = out_res.last_of_run;

endmodule
